// ===== hw/rtl/token_bucket_rate_limiter_unit_defines.svh =====
// assertion macros shared by the rate limiter modules
// both expect clk and rst_n in the scope where they are used
`ifndef TOKEN_BUCKET_RATE_LIMITER_UNIT_DEFINES_SVH
`define TOKEN_BUCKET_RATE_LIMITER_UNIT_DEFINES_SVH

// same-cycle implication
`define TBRL_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbrl assertion failed");

// next-cycle implication
`define TBRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbrl assertion failed");

`endif

// ===== hw/rtl/tbrl_pkg.sv =====
package tbrl_pkg;

    // field widths
    localparam int STAMP_W    = 63;
    localparam int PERIOD_W   = 40;
    localparam int CAP_W      = 16;
    localparam int LEVEL_W    = 46;
    localparam int SCALE_W    = 30;
    localparam int MUL_A_W    = 32;
    localparam int MUL_P_W    = 62;
    localparam int NUM_W      = 93;
    localparam int QUO_W      = LEVEL_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 46;

    // one whole token in level units
    localparam logic [SCALE_W-1:0] TOKEN_SCALE = 30'd1000000000;

    // register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 40'd1000000000;
    localparam logic [CAP_W-1:0]    CAP_RESET    = 16'd1;
    localparam logic [LEVEL_W-1:0]  INIT_RESET   = '0;
    // initial level clamped to the reset capacity
    localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = '0;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD      = 2'd0,
        CFG_CAPACITY    = 2'd1,
        CFG_INIT_TOKENS = 2'd2
    } cfg_index_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== hw/rtl/tbrl_if.sv =====
// message item channel
interface tbrl_msg_if;
    logic                         valid;
    logic                         ready;
    logic [tbrl_pkg::STAMP_W-1:0] stamp_ns;
    logic                         clock_jumped;

    modport source (output valid, output stamp_ns, output clock_jumped, input ready);
    modport sink (input valid, input stamp_ns, input clock_jumped, output ready);
endinterface

// verdict item channel
interface tbrl_verdict_if;
    logic                         valid;
    logic                         ready;
    logic                         allow;
    logic [tbrl_pkg::LEVEL_W-1:0] tokens_left;

    modport source (output valid, output allow, output tokens_left, input ready);
    modport sink (input valid, input allow, input tokens_left, output ready);
endinterface

// configuration write channel
interface tbrl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tbrl_pkg::CFG_IDX_W-1:0]  index;
    logic [tbrl_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/token_bucket_rate_limiter_unit.sv =====
// token bucket rate limiter
// msg carries a message time stamp in ns and a clock_jumped flag; verdict
// returns allow and the token level left after the check, in units of one
// billionth of a token. cfg writes period_ns (0), capacity (1) and
// initial_tokens (2); it is always ready and should be written only while
// no item is in flight.
// one item at a time: msg.ready is high only while the block is idle.
// a normal item runs the setup steps (capacity product, restart, elapsed
// time, the partial products of the low 32 and high 31 bits of elapsed
// time by the token scale, and the accumulate that starts the divider),
// then the 93 restoring steps of the divider, a done step and a spend
// step before verdict.valid. a stamp going back, or a zero period, skips
// the multiply and divide.
// the next item can be accepted from the cycle after its verdict is loaded.
// reset restores the register defaults, clears the last check time and
// empties the bucket. a verdict the receiver has not taken sits in the
// output register; a finished item waits in its spend step until the
// register is free, so no verdict is lost.
`include "token_bucket_rate_limiter_unit_defines.svh"

module token_bucket_rate_limiter_unit (
    input  logic        clk,
    input  logic        rst_n,
    tbrl_msg_if.sink       msg,
    tbrl_verdict_if.source verdict,
    tbrl_cfg_if.sink       cfg
);
    import tbrl_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CAP   = 9'b000000010,
        S_PRE   = 9'b000000100,
        S_DT    = 9'b000001000,
        S_MLO   = 9'b000010000,
        S_MHI   = 9'b000100000,
        S_MACC  = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_SPEND = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [CAP_W-1:0]    capacity_reg, capacity_next;
    logic [LEVEL_W-1:0]  init_reg, init_next;
    logic [STAMP_W-1:0]  last_reg, last_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic                out_valid_reg, out_valid_next;

    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    logic                jumped_reg, jumped_next;
    logic [LEVEL_W-1:0]  cap_reg, cap_next;
    logic [STAMP_W-1:0]  dt_reg, dt_next;
    logic [MUL_P_W-1:0]  lo_reg, lo_next;
    logic                refused_reg, refused_next;
    logic                allow_reg, allow_next;
    logic [LEVEL_W-1:0]  tokens_reg, tokens_next;

    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_P_W-1:0]  mul_p;
    logic                div_start;
    logic [QUO_W-1:0]    div_quo;
    div_status_t         div_status;

    logic [LEVEL_W-1:0]  cap_prod;
    logic [LEVEL_W-1:0]  init_clamped;
    logic [STAMP_W:0]    dt_diff;
    logic                back;
    logic [NUM_W:0]      num_full;
    logic [QUO_W:0]      level_sum;
    logic [LEVEL_W-1:0]  level_refill;
    logic                can_spend;
    logic                out_free;
    logic                load;

    // shared constant-scale multiplier
    tbrl_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .p   (mul_p)
    );

    // restoring divider
    tbrl_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (num_full[NUM_W-1:0]),
        .per    (period_reg),
        .limit  (cap_reg),
        .quo    (div_quo),
        .status (div_status)
    );

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_CAP:   mul_a = MUL_A_W'(capacity_reg);
            S_MLO:   mul_a = dt_reg[MUL_A_W-1:0];
            S_MHI:   mul_a = MUL_A_W'(dt_reg[STAMP_W-1:MUL_A_W]);
            default: mul_a = '0;
        endcase
    end

    // datapath helpers
    assign cap_prod     = mul_p[LEVEL_W-1:0];
    assign init_clamped = (init_reg < cap_prod) ? init_reg : cap_prod;
    assign dt_diff      = {1'b0, stamp_reg} - {1'b0, last_reg};
    assign back         = dt_diff[STAMP_W];
    assign num_full     = {mul_p, {MUL_A_W{1'b0}}} + (NUM_W + 1)'(lo_reg);
    assign level_sum    = (QUO_W + 1)'(level_reg) + (QUO_W + 1)'(div_quo);
    assign level_refill = (level_sum > (QUO_W + 1)'(cap_reg)) ? cap_reg
                                                             : level_sum[LEVEL_W-1:0];
    assign can_spend    = !refused_reg && (level_reg >= LEVEL_W'(TOKEN_SCALE));
    assign out_free     = !out_valid_reg || verdict.ready;
    assign load         = (state_reg == S_SPEND) && out_free;
    assign div_start    = (state_reg == S_MACC);

    // sequencer and configuration
    always_comb
    begin
        state_next     = state_reg;
        period_next    = period_reg;
        capacity_next  = capacity_reg;
        init_next      = init_reg;
        last_next      = last_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg;
        stamp_next     = stamp_reg;
        jumped_next    = jumped_reg;
        cap_next       = cap_reg;
        dt_next        = dt_reg;
        lo_next        = lo_reg;
        refused_next   = refused_reg;
        allow_next     = allow_reg;
        tokens_next    = tokens_reg;

        // register writes
        if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_PERIOD:      period_next   = cfg.data[PERIOD_W-1:0];
                CFG_CAPACITY:    capacity_next = cfg.data[CAP_W-1:0];
                CFG_INIT_TOKENS: init_next     = cfg.data[LEVEL_W-1:0];
                default:         ;
            endcase
        end

        // verdict handoff
        if (verdict.valid && verdict.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (msg.valid)
                begin
                    stamp_next  = msg.stamp_ns;
                    jumped_next = msg.clock_jumped;
                    state_next  = S_CAP;
                end
            end
            S_CAP:
            begin
                state_next = S_PRE;
            end
            S_PRE:
            begin
                // restart and first-check handling
                cap_next = cap_prod;
                if (jumped_reg)
                begin
                    level_next = init_clamped;
                end
                if (jumped_reg || last_reg == '0)
                begin
                    last_next = stamp_reg;
                end
                state_next = S_DT;
            end
            S_DT:
            begin
                dt_next      = dt_diff[STAMP_W-1:0];
                last_next    = stamp_reg;
                refused_next = back;
                if (back)
                begin
                    state_next = S_SPEND;
                end
                else if (period_reg == '0)
                begin
                    level_next = cap_reg;
                    state_next = S_SPEND;
                end
                else
                begin
                    state_next = S_MLO;
                end
            end
            S_MLO:
            begin
                state_next = S_MHI;
            end
            S_MHI:
            begin
                lo_next    = mul_p;
                state_next = S_MACC;
            end
            S_MACC:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    level_next = level_refill;
                    state_next = S_SPEND;
                end
            end
            S_SPEND:
            begin
                if (out_free)
                begin
                    allow_next     = can_spend;
                    tokens_next    = can_spend ? level_reg - LEVEL_W'(TOKEN_SCALE) : level_reg;
                    level_next     = tokens_next;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            period_reg    <= PERIOD_RESET;
            capacity_reg  <= CAP_RESET;
            init_reg      <= INIT_RESET;
            last_reg      <= '0;
            level_reg     <= LEVEL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            period_reg    <= period_next;
            capacity_reg  <= capacity_next;
            init_reg      <= init_next;
            last_reg      <= last_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        stamp_reg   <= stamp_next;
        jumped_reg  <= jumped_next;
        cap_reg     <= cap_next;
        dt_reg      <= dt_next;
        lo_reg      <= lo_next;
        refused_reg <= refused_next;
        allow_reg   <= allow_next;
        tokens_reg  <= tokens_next;
    end

    // channel outputs
    assign msg.ready           = (state_reg == S_IDLE);
    assign cfg.ready           = 1'b1;
    assign verdict.valid       = out_valid_reg;
    assign verdict.allow       = allow_reg;
    assign verdict.tokens_left = tokens_reg;

    `TBRL_ASSERT(div_needs_period, div_start, (period_reg != '0))
    `TBRL_ASSERT_NEXT(refused_is_dropped, (load && refused_reg), (verdict.valid && !verdict.allow))
    `TBRL_ASSERT_NEXT(level_within_cap, (load && !refused_reg), (verdict.tokens_left <= cap_reg))
    `TBRL_ASSERT(div_only_while_dividing, div_status.busy, (state_reg == S_DIV))

endmodule

// ===== hw/rtl/tbrl_mul.sv =====
module tbrl_mul (
    input  logic                         clk,
    input  logic [tbrl_pkg::MUL_A_W-1:0] a,
    output logic [tbrl_pkg::MUL_P_W-1:0] p
);
    import tbrl_pkg::*;

    logic [MUL_P_W-1:0] p_reg;
    logic [MUL_P_W-1:0] p_next;

    // operand times one token, product fits 62 bits
    assign p_next = MUL_P_W'(a) * MUL_P_W'(TOKEN_SCALE);

    // registered product
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/tbrl_div.sv =====
`include "token_bucket_rate_limiter_unit_defines.svh"

module tbrl_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tbrl_pkg::NUM_W-1:0]    num,
    input  logic [tbrl_pkg::PERIOD_W-1:0] per,
    input  logic [tbrl_pkg::LEVEL_W-1:0]  limit,
    output logic [tbrl_pkg::QUO_W-1:0]    quo,
    output tbrl_pkg::div_status_t         status
);
    import tbrl_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]    q_reg, q_next;
    logic                sat_reg, sat_next;
    logic [PERIOD_W-1:0] per_reg, per_next;
    logic [LEVEL_W-1:0]  limit_reg, limit_next;

    logic [PERIOD_W:0]   rem_sh;
    logic [PERIOD_W:0]   rem_sub;
    logic                ge;
    logic [QUO_W-1:0]    q_sh;
    logic [QUO_W-1:0]    q_sat;
    logic                over;

    // one restoring step: shift in a numerator bit, trial subtract
    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, per_reg};
    assign ge      = rem_sh >= {1'b0, per_reg};

    // quotient grows monotonically, so clamp once it passes the limit
    assign q_sh  = {q_reg[QUO_W-2:0], ge};
    assign q_sat = {1'b0, limit_reg} + QUO_W'(1);
    assign over  = q_sh > {1'b0, limit_reg};

    // step sequencing
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        sat_next   = sat_reg;
        per_next   = per_reg;
        limit_next = limit_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(NUM_W - 1);
            num_next   = num;
            rem_next   = '0;
            q_next     = '0;
            sat_next   = 1'b0;
            per_next   = per;
            limit_next = limit;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            rem_next = ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
            if (!sat_reg)
            begin
                if (over)
                begin
                    sat_next = 1'b1;
                    q_next   = q_sat;
                end
                else
                begin
                    q_next = q_sh;
                end
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        sat_reg   <= sat_next;
        per_reg   <= per_next;
        limit_reg <= limit_next;
    end

    assign quo         = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    `TBRL_ASSERT(div_start_when_idle, start, !busy_reg)
    `TBRL_ASSERT_NEXT(div_last_step_done, (busy_reg && cnt_reg == '0), (done_reg && !busy_reg))
    `TBRL_ASSERT(div_quo_bounded, busy_reg, (q_reg <= q_sat))
    `TBRL_ASSERT(div_sat_holds_cap, (busy_reg && sat_reg), (q_reg == q_sat))

endmodule
